[rtl/amix_pkg.sv]
// ----------------------------------------------------------------------------
// amix_pkg
// shared widths, constants and state codes of the adaptive gain pcm mixer
// ----------------------------------------------------------------------------
`default_nettype none

package amix_pkg;

  localparam int unsigned PcmWidth   = 16;
  localparam int unsigned SumWidth   = PcmWidth + 1;
  localparam int unsigned GainWidth  = 17;
  localparam int unsigned ShiftWidth = 4;
  localparam int unsigned CntWidth   = 4;

  localparam logic [GainWidth-1:0]  GainUnity     = 17'h10000;
  localparam logic [ShiftWidth-1:0] ShiftReset    = 4'd5;
  localparam logic [PcmWidth-1:0]   PcmMax        = 16'h7fff;
  localparam logic [PcmWidth-1:0]   PcmMin        = 16'h8000;
  localparam logic [SumWidth-1:0]   PcmMaxMag     = 17'h07fff;
  localparam logic [SumWidth-1:0]   PcmMinMag     = 17'h08000;
  localparam logic [CntWidth-1:0]   MulLastStep   = 4'd8;
  localparam logic [CntWidth-1:0]   DivLastStep   = 4'd7;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StAbs   = 7'b0000010,
    StMul   = 7'b0000100,
    StChk   = 7'b0001000,
    StDiv   = 7'b0010000,
    StRecov = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

[rtl/adaptive_gain_pcm_mixer.sv]
// ----------------------------------------------------------------------------
// adaptive_gain_pcm_mixer
// two-stream pcm mixer with adaptive attenuation gain, radix-4 serial
// multiply and radix-4 serial restoring divide
// ----------------------------------------------------------------------------
// steps: accept, absolute value, serial multiply, clip check, divide when
//   the item clips and the new gain is divided out, recovery, output
// one item at a time: the input stalls until the result leaves the output
//   step; the 9-step multiplier and the 8-step divider share one sequencer
// reset: asynchronous active low, gain returns to unity and recovery shift to 5
`default_nettype none

module adaptive_gain_pcm_mixer (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [amix_pkg::ShiftWidth-1:0]       cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire signed [amix_pkg::PcmWidth-1:0]  sample_a_i,
  input  wire signed [amix_pkg::PcmWidth-1:0]  sample_b_i,
  input  wire                                  frame_start_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [amix_pkg::PcmWidth-1:0] mixed_sample_o
);

  import amix_pkg::*;

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   cnt_q;
  logic [ShiftWidth-1:0] shift_q;
  logic [GainWidth-1:0]  gain_q;
  logic [SumWidth-1:0]   sum_q;
  logic                  sign_q;
  logic [SumWidth-1:0]   mag_q;
  logic [GainWidth:0]    mul_q;
  logic [SumWidth-1:0]   hi_q;
  logic [1:0]            lo_q;
  logic [SumWidth-1:0]   rem_q;
  logic [PcmWidth-1:0]   quo_q;
  logic                  clip_q;
  logic [PcmWidth-1:0]   res_q;
  logic                  out_valid_q;
  logic [PcmWidth-1:0]   out_data_q;

  logic                  in_acc;
  logic                  out_load;
  logic [SumWidth+1:0]   mul_sum;
  logic [SumWidth-1:0]   scaled;
  logic                  clip_pos;
  logic                  clip_neg;
  logic [SumWidth:0]     r1;
  logic                  ge1;
  logic [SumWidth-1:0]   r1s;
  logic [SumWidth:0]     r2;
  logic                  ge2;
  logic [SumWidth-1:0]   r2s;
  logic [GainWidth-1:0]  gain_base;
  logic [GainWidth-1:0]  gain_dist;

  assign in_stall_o     = (state_q != StIdle);
  assign in_acc         = in_valid_i && !in_stall_o;
  assign out_load       = (state_q == StOut) && (!out_valid_q || !out_stall_i);
  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_data_q;

  // one radix-4 digit of the multiplier
  always_comb begin
    mul_sum = {2'b00, hi_q}
            + (mul_q[0] ? {2'b00, mag_q} : '0)
            + (mul_q[1] ? {1'b0, mag_q, 1'b0} : '0);
  end

  assign scaled   = {hi_q[SumWidth-3:0], lo_q};
  assign clip_pos = !sign_q && (scaled > PcmMaxMag);
  assign clip_neg = sign_q && (scaled > PcmMinMag);

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem_q, 1'b0};
    ge1 = (r1 >= {1'b0, mag_q});
    r1s = ge1 ? SumWidth'(r1 - {1'b0, mag_q}) : r1[SumWidth-1:0];
    r2  = {r1s, 1'b0};
    ge2 = (r2 >= {1'b0, mag_q});
    r2s = ge2 ? SumWidth'(r2 - {1'b0, mag_q}) : r2[SumWidth-1:0];
  end

  assign gain_base = clip_q ? {1'b0, quo_q} : gain_q;
  assign gain_dist = (GainUnity - gain_base) >> shift_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = StAbs;
      StAbs:   state_d = StMul;
      StMul:   if (cnt_q == MulLastStep) state_d = StChk;
      StChk:   state_d = (clip_pos || clip_neg) ? StDiv : StRecov;
      StDiv:   if (cnt_q == DivLastStep) state_d = StRecov;
      StRecov: state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      shift_q     <= ShiftReset;
      gain_q      <= GainUnity;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
      if (in_acc && frame_start_i) begin
        gain_q <= GainUnity;
      end
      if (state_q == StRecov) begin
        gain_q <= GainWidth'(gain_base + gain_dist);
      end
      if (state_q == StMul || state_q == StDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q <= SumWidth'({sample_a_i[PcmWidth-1], sample_a_i})
             + SumWidth'({sample_b_i[PcmWidth-1], sample_b_i});
    end
    case (state_q)
      StAbs: begin
        sign_q <= sum_q[SumWidth-1];
        mag_q  <= sum_q[SumWidth-1] ? SumWidth'(-sum_q) : sum_q;
        mul_q  <= {1'b0, gain_q};
        hi_q   <= '0;
        lo_q   <= '0;
      end
      StMul: begin
        hi_q  <= mul_sum[SumWidth+1:2];
        lo_q  <= mul_sum[1:0];
        mul_q <= {2'b00, mul_q[GainWidth:2]};
      end
      StChk: begin
        clip_q <= clip_pos || clip_neg;
        mag_q  <= scaled;
        rem_q  <= clip_pos ? PcmMaxMag : PcmMinMag;
        quo_q  <= '0;
        if (clip_pos) begin
          res_q <= PcmMax;
        end else if (clip_neg) begin
          res_q <= PcmMin;
        end else if (sign_q) begin
          res_q <= PcmWidth'(-scaled[PcmWidth-1:0]);
        end else begin
          res_q <= scaled[PcmWidth-1:0];
        end
      end
      StDiv: begin
        rem_q <= r2s;
        quo_q <= {quo_q[PcmWidth-3:0], ge1, ge2};
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

endmodule

`default_nettype wire

[rtl/amix_chk.sv]
// ----------------------------------------------------------------------------
// amix_chk
// port-level checks of the adaptive gain pcm mixer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module amix_chk (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_stall_o,
  input wire                                 out_valid_o,
  input wire                                 out_stall_i,
  input wire [amix_pkg::PcmWidth-1:0]        mixed_sample_o
);

  import amix_pkg::*;

  // a stalled result item stays
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mixed_sample_o))
    else $error("stalled result item changed");

  // one item at a time
  a_busy_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after an item");

  // the serial multiply keeps the block busy
  a_busy_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##13 in_stall_o)
    else $error("item finished faster than the serial datapath allows");

  // a new result appears only from the output step
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item raised while the block was idle");

endmodule

bind adaptive_gain_pcm_mixer amix_chk u_amix_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .mixed_sample_o (mixed_sample_o)
);

`default_nettype wire
